@@ design/sql_token_scanner_defines.svh @@
// Assertion macros for the SQL token scanner.
// Used by the top level. Needs no other file.
`ifndef SQL_TOKEN_SCANNER_DEFINES_SVH
`define SQL_TOKEN_SCANNER_DEFINES_SVH
`ifndef SYNTHESIS
`define SQLTS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SQLTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SQLTS_ASSERT(lbl, clk, rst, prop, msg)
`define SQLTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ design/sqlts_pkg.sv @@
// Types, token codes and the keyword table of the SQL token scanner.
// Used by every module of the scanner. Depends on nothing.
`default_nettype none
package sqlts_pkg;

   localparam int POS_BITS   = 20;
   localparam int LC_BITS    = 16;
   localparam int KIND_BITS  = 7;
   localparam int KW_MAX_LEN = 14;
   localparam int KW_COUNT   = 61;
   localparam int Q_DEPTH    = 4;

   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
   localparam logic [LC_BITS-1:0]  LC_MAX  = {LC_BITS{1'b1}};

   localparam logic [KIND_BITS-1:0] K_LPAREN  = 7'd0;
   localparam logic [KIND_BITS-1:0] K_RPAREN  = 7'd1;
   localparam logic [KIND_BITS-1:0] K_COMMA   = 7'd2;
   localparam logic [KIND_BITS-1:0] K_DOT     = 7'd3;
   localparam logic [KIND_BITS-1:0] K_SEMI    = 7'd4;
   localparam logic [KIND_BITS-1:0] K_PLUS    = 7'd5;
   localparam logic [KIND_BITS-1:0] K_MINUS   = 7'd6;
   localparam logic [KIND_BITS-1:0] K_STAR    = 7'd7;
   localparam logic [KIND_BITS-1:0] K_SLASH   = 7'd8;
   localparam logic [KIND_BITS-1:0] K_PERCENT = 7'd9;
   localparam logic [KIND_BITS-1:0] K_EQ      = 7'd10;
   localparam logic [KIND_BITS-1:0] K_NE      = 7'd11;
   localparam logic [KIND_BITS-1:0] K_LT      = 7'd12;
   localparam logic [KIND_BITS-1:0] K_LE      = 7'd13;
   localparam logic [KIND_BITS-1:0] K_GT      = 7'd14;
   localparam logic [KIND_BITS-1:0] K_GE      = 7'd15;
   localparam logic [KIND_BITS-1:0] K_INT     = 7'd16;
   localparam logic [KIND_BITS-1:0] K_FLOAT   = 7'd17;
   localparam logic [KIND_BITS-1:0] K_STRING  = 7'd18;
   localparam logic [KIND_BITS-1:0] K_IDENT   = 7'd19;
   localparam logic [KIND_BITS-1:0] K_KW0     = 7'd20;
   localparam logic [KIND_BITS-1:0] K_UNKNOWN = 7'd81;
   localparam logic [KIND_BITS-1:0] K_END     = 7'd82;

   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   typedef enum logic [3:0] {
      M_IDLE, M_MINUS, M_SLASH, M_BANG, M_LT, M_GT, M_LINECOM, M_BLOCK,
      M_BLOCKSTAR, M_STRING, M_INT, M_INTDOT, M_FLOAT, M_IDENT
   } mode_type;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [LC_BITS-1:0]   line;
      logic [LC_BITS-1:0]   column;
      logic [POS_BITS-1:0]  offset;
      logic [POS_BITS-1:0]  length;
   } token_type;

   typedef struct packed {
      logic [1:0]           count;
      token_type [2:0]      tok;
   } bundle_type;

   typedef struct packed {
      mode_type             mode;
      logic [POS_BITS-1:0]  pos;
   } front_status_type;

   typedef logic [KW_MAX_LEN-1:0][7:0] kw_buf_type;

   localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [KW_COUNT] = '{
      "CREATE", "TABLE", "DROP", "ALTER", "ADD", "COLUMN", "SELECT", "FROM",
      "WHERE", "INSERT", "INTO", "VALUES", "UPDATE", "SET", "DELETE", "ORDER",
      "BY", "ASC", "DESC", "LIMIT", "GROUP", "HAVING", "AS", "DISTINCT",
      "JOIN", "INNER", "LEFT", "RIGHT", "ON", "CROSS", "AND", "OR", "NOT", "IN",
      "BETWEEN", "LIKE", "IS", "NULL", "TRUE", "FALSE", "EXISTS", "INT",
      "FLOAT", "VARCHAR", "BOOL", "DATE", "TEXT", "PRIMARY", "KEY", "DEFAULT",
      "UNIQUE", "AUTOINCREMENT", {"AUTO_", "INCREMENT"}, "SHOW", "TABLES",
      "DESCRIBE", "COUNT", "SUM", "AVG", "MIN", "MAX"
   };

   localparam logic [4:0] KW_LEN [KW_COUNT] = '{
      5'd6, 5'd5, 5'd4, 5'd5, 5'd3, 5'd6, 5'd6, 5'd4,
      5'd5, 5'd6, 5'd4, 5'd6, 5'd6, 5'd3, 5'd6, 5'd5,
      5'd2, 5'd3, 5'd4, 5'd5, 5'd5, 5'd6, 5'd2, 5'd8,
      5'd4, 5'd5, 5'd4, 5'd5, 5'd2, 5'd5, 5'd3, 5'd2, 5'd3, 5'd2,
      5'd7, 5'd4, 5'd2, 5'd4, 5'd4, 5'd5, 5'd6, 5'd3,
      5'd5, 5'd7, 5'd4, 5'd4, 5'd4, 5'd7, 5'd3, 5'd7,
      5'd6, 5'd13, 5'd14, 5'd4, 5'd6,
      5'd8, 5'd5, 5'd3, 5'd3, 5'd3, 5'd3
   };

   // Literals are right-justified, so character j of an entry of length L
   // sits at byte L-1-j.
   function automatic logic [KIND_BITS-1:0] kw_kind(input kw_buf_type kb,
                                                    input logic [4:0] len);
      logic [KIND_BITS-1:0] kind;
      logic                 found;
      logic                 match;
      int                   idx;
      kind  = K_IDENT;
      found = 1'b0;
      for (int i = 0; i < KW_COUNT; i++) begin
         match = (KW_LEN[i] == len);
         for (int j = 0; j < KW_MAX_LEN; j++) begin
            idx = int'(KW_LEN[i]) - 1 - j;
            if (idx >= 0) begin
               if (kb[j] != KW_TEXT[i][idx*8 +: 8]) begin
                  match = 1'b0;
               end
            end
         end
         if (match && !found) begin
            found = 1'b1;
            kind  = KIND_BITS'(int'(K_KW0) + i);
         end
      end
      return kind;
   endfunction

endpackage
`default_nettype wire

@@ design/sqlts_front.sv @@
// Front part of the SQL token scanner: scan mode machine and token builder.
// Depends on sqlts_pkg; produces one bundle of up to three tokens per item.
`default_nettype none
module sqlts_front
   import sqlts_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire logic             action,
   input  wire logic [7:0]       text_byte,
   output logic                  push,
   output bundle_type            bundle,
   output front_status_type      status
);

   mode_type            mode_ff, mode_in;
   kw_buf_type          kbuf_ff, kbuf_in;
   logic                ovf_ff, ovf_in;
   logic [POS_BITS-1:0] pos_ff, pos_in, tsp_ff, tsp_in;
   logic [LC_BITS-1:0]  line_ff, line_in, col_ff, col_in;
   logic [LC_BITS-1:0]  tsl_ff, tsl_in, tsc_ff, tsc_in;

   logic [POS_BITS-1:0] span, ilen;
   logic [POS_BITS:0]   dot_col;
   logic [1:0]          cnt;
   token_type [2:0]     toks;
   logic                again;
   logic                is_dig, is_alp, is_wrd;

   function automatic token_type mk(input logic [KIND_BITS-1:0] k,
                                    input logic [LC_BITS-1:0] l,
                                    input logic [LC_BITS-1:0] c,
                                    input logic [POS_BITS-1:0] o,
                                    input logic [POS_BITS-1:0] n);
      token_type t;
      t.kind   = k;
      t.line   = l;
      t.column = c;
      t.offset = o;
      t.length = n;
      return t;
   endfunction

   function automatic logic [7:0] upper(input logic [7:0] b);
      return (b >= "a" && b <= "z") ? b - 8'd32 : b;
   endfunction

   always_comb begin
      mode_in = mode_ff;
      kbuf_in = kbuf_ff;
      ovf_in  = ovf_ff;
      pos_in  = pos_ff;
      tsp_in  = tsp_ff;
      line_in = line_ff;
      col_in  = col_ff;
      tsl_in  = tsl_ff;
      tsc_in  = tsc_ff;
      cnt     = 2'd0;
      toks    = '0;
      again   = 1'b0;
      is_dig  = (text_byte >= "0" && text_byte <= "9");
      is_alp  = (text_byte >= "A" && text_byte <= "Z") ||
                (text_byte >= "a" && text_byte <= "z");
      is_wrd  = is_dig || is_alp || (text_byte == "_");
      span    = (pos_ff >= tsp_ff) ? pos_ff - tsp_ff : '0;
      ilen    = (span != '0) ? span - 1'b1 : '0;
      dot_col = {{(POS_BITS+1-LC_BITS){1'b0}}, tsc_ff} + {1'b0, ilen};

      if (!action) begin
         unique case (mode_ff)
            M_IDLE: again = 1'b1;
            M_MINUS: begin
               if (text_byte == "-") begin
                  mode_in = M_LINECOM;
               end else begin
                  toks[cnt] = mk(K_MINUS, tsl_ff, tsc_ff, tsp_ff, 1);
                  cnt = cnt + 2'd1;
                  again = 1'b1;
               end
            end
            M_SLASH: begin
               if (text_byte == "*") begin
                  mode_in = M_BLOCK;
               end else begin
                  toks[cnt] = mk(K_SLASH, tsl_ff, tsc_ff, tsp_ff, 1);
                  cnt = cnt + 2'd1;
                  again = 1'b1;
               end
            end
            M_BANG: begin
               if (text_byte == "=") begin
                  toks[cnt] = mk(K_NE, tsl_ff, tsc_ff, tsp_ff, 2);
                  cnt = cnt + 2'd1;
                  mode_in = M_IDLE;
               end else begin
                  toks[cnt] = mk(K_UNKNOWN, tsl_ff, tsc_ff, tsp_ff, 1);
                  cnt = cnt + 2'd1;
                  again = 1'b1;
               end
            end
            M_LT: begin
               if (text_byte == "=") begin
                  toks[cnt] = mk(K_LE, tsl_ff, tsc_ff, tsp_ff, 2);
                  cnt = cnt + 2'd1;
                  mode_in = M_IDLE;
               end else if (text_byte == ">") begin
                  toks[cnt] = mk(K_NE, tsl_ff, tsc_ff, tsp_ff, 2);
                  cnt = cnt + 2'd1;
                  mode_in = M_IDLE;
               end else begin
                  toks[cnt] = mk(K_LT, tsl_ff, tsc_ff, tsp_ff, 1);
                  cnt = cnt + 2'd1;
                  again = 1'b1;
               end
            end
            M_GT: begin
               if (text_byte == "=") begin
                  toks[cnt] = mk(K_GE, tsl_ff, tsc_ff, tsp_ff, 2);
                  cnt = cnt + 2'd1;
                  mode_in = M_IDLE;
               end else begin
                  toks[cnt] = mk(K_GT, tsl_ff, tsc_ff, tsp_ff, 1);
                  cnt = cnt + 2'd1;
                  again = 1'b1;
               end
            end
            M_LINECOM: begin
               if (text_byte == CH_LF) begin
                  mode_in = M_IDLE;
               end
            end
            M_BLOCK: begin
               if (text_byte == "*") begin
                  mode_in = M_BLOCKSTAR;
               end
            end
            M_BLOCKSTAR: begin
               if (text_byte == "/") begin
                  mode_in = M_IDLE;
               end else if (text_byte != "*") begin
                  mode_in = M_BLOCK;
               end
            end
            M_STRING: begin
               if (text_byte == "'") begin
                  toks[cnt] = mk(K_STRING, tsl_ff, tsc_ff,
                                 (tsp_ff < POS_MAX) ? tsp_ff + 1'b1 : POS_MAX, ilen);
                  cnt = cnt + 2'd1;
                  mode_in = M_IDLE;
               end
            end
            M_INT: begin
               if (text_byte == ".") begin
                  mode_in = M_INTDOT;
               end else if (!is_dig) begin
                  toks[cnt] = mk(K_INT, tsl_ff, tsc_ff, tsp_ff, span);
                  cnt = cnt + 2'd1;
                  again = 1'b1;
               end
            end
            M_INTDOT: begin
               if (is_dig) begin
                  mode_in = M_FLOAT;
               end else begin
                  toks[cnt] = mk(K_INT, tsl_ff, tsc_ff, tsp_ff, ilen);
                  cnt = cnt + 2'd1;
                  toks[cnt] = mk(K_DOT, tsl_ff,
                                 (dot_col > {{(POS_BITS+1-LC_BITS){1'b0}}, LC_MAX}) ?
                                    LC_MAX : dot_col[LC_BITS-1:0],
                                 tsp_ff + ilen, 1);
                  cnt = cnt + 2'd1;
                  again = 1'b1;
               end
            end
            M_FLOAT: begin
               if (!is_dig) begin
                  toks[cnt] = mk(K_FLOAT, tsl_ff, tsc_ff, tsp_ff, span);
                  cnt = cnt + 2'd1;
                  again = 1'b1;
               end
            end
            M_IDENT: begin
               if (is_wrd) begin
                  if (span < POS_BITS'(KW_MAX_LEN)) begin
                     kbuf_in[span[3:0]] = upper(text_byte);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end else begin
                  toks[cnt] = mk((!ovf_ff && span <= POS_BITS'(KW_MAX_LEN)) ?
                                    kw_kind(kbuf_ff, span[4:0]) : K_IDENT,
                                 tsl_ff, tsc_ff, tsp_ff, span);
                  cnt = cnt + 2'd1;
                  again = 1'b1;
               end
            end
            default: again = 1'b1;
         endcase

         if (again) begin
            mode_in = M_IDLE;
            tsp_in  = pos_ff;
            tsl_in  = line_ff;
            tsc_in  = col_ff;
            unique case (text_byte)
               "(": begin toks[cnt] = mk(K_LPAREN, line_ff, col_ff, pos_ff, 1);
                  cnt = cnt + 2'd1; end
               ")": begin toks[cnt] = mk(K_RPAREN, line_ff, col_ff, pos_ff, 1);
                  cnt = cnt + 2'd1; end
               ",": begin toks[cnt] = mk(K_COMMA, line_ff, col_ff, pos_ff, 1);
                  cnt = cnt + 2'd1; end
               ".": begin toks[cnt] = mk(K_DOT, line_ff, col_ff, pos_ff, 1);
                  cnt = cnt + 2'd1; end
               ";": begin toks[cnt] = mk(K_SEMI, line_ff, col_ff, pos_ff, 1);
                  cnt = cnt + 2'd1; end
               "+": begin toks[cnt] = mk(K_PLUS, line_ff, col_ff, pos_ff, 1);
                  cnt = cnt + 2'd1; end
               "*": begin toks[cnt] = mk(K_STAR, line_ff, col_ff, pos_ff, 1);
                  cnt = cnt + 2'd1; end
               "%": begin toks[cnt] = mk(K_PERCENT, line_ff, col_ff, pos_ff, 1);
                  cnt = cnt + 2'd1; end
               "=": begin toks[cnt] = mk(K_EQ, line_ff, col_ff, pos_ff, 1);
                  cnt = cnt + 2'd1; end
               "-": mode_in = M_MINUS;
               "/": mode_in = M_SLASH;
               "!": mode_in = M_BANG;
               "<": mode_in = M_LT;
               ">": mode_in = M_GT;
               " ", CH_CR, CH_TAB, CH_LF: mode_in = M_IDLE;
               "'": mode_in = M_STRING;
               default: begin
                  if (is_dig) begin
                     mode_in = M_INT;
                  end else if (is_alp || text_byte == "_") begin
                     mode_in = M_IDENT;
                     ovf_in = 1'b0;
                     kbuf_in[0] = upper(text_byte);
                  end else begin
                     toks[cnt] = mk(K_UNKNOWN, line_ff, col_ff, pos_ff, 1);
                     cnt = cnt + 2'd1;
                  end
               end
            endcase
         end

         if (pos_ff < POS_MAX) begin
            pos_in = pos_ff + 1'b1;
         end
         if (text_byte == CH_LF) begin
            if (line_ff < LC_MAX) begin
               line_in = line_ff + 1'b1;
            end
            col_in = 1;
         end else if (col_ff < LC_MAX) begin
            col_in = col_ff + 1'b1;
         end
      end else begin
         unique case (mode_ff)
            M_MINUS: begin toks[cnt] = mk(K_MINUS, tsl_ff, tsc_ff, tsp_ff, 1);
               cnt = cnt + 2'd1; end
            M_SLASH: begin toks[cnt] = mk(K_SLASH, tsl_ff, tsc_ff, tsp_ff, 1);
               cnt = cnt + 2'd1; end
            M_BANG: begin toks[cnt] = mk(K_UNKNOWN, tsl_ff, tsc_ff, tsp_ff, 1);
               cnt = cnt + 2'd1; end
            M_LT: begin toks[cnt] = mk(K_LT, tsl_ff, tsc_ff, tsp_ff, 1);
               cnt = cnt + 2'd1; end
            M_GT: begin toks[cnt] = mk(K_GT, tsl_ff, tsc_ff, tsp_ff, 1);
               cnt = cnt + 2'd1; end
            M_STRING: begin toks[cnt] = mk(K_UNKNOWN, tsl_ff, tsc_ff, tsp_ff, span);
               cnt = cnt + 2'd1; end
            M_INT: begin toks[cnt] = mk(K_INT, tsl_ff, tsc_ff, tsp_ff, span);
               cnt = cnt + 2'd1; end
            M_INTDOT: begin
               toks[cnt] = mk(K_INT, tsl_ff, tsc_ff, tsp_ff, ilen);
               cnt = cnt + 2'd1;
               toks[cnt] = mk(K_DOT, tsl_ff,
                              (dot_col > {{(POS_BITS+1-LC_BITS){1'b0}}, LC_MAX}) ?
                                 LC_MAX : dot_col[LC_BITS-1:0],
                              tsp_ff + ilen, 1);
               cnt = cnt + 2'd1;
            end
            M_FLOAT: begin toks[cnt] = mk(K_FLOAT, tsl_ff, tsc_ff, tsp_ff, span);
               cnt = cnt + 2'd1; end
            M_IDENT: begin
               toks[cnt] = mk((!ovf_ff && span <= POS_BITS'(KW_MAX_LEN)) ?
                                 kw_kind(kbuf_ff, span[4:0]) : K_IDENT,
                              tsl_ff, tsc_ff, tsp_ff, span);
               cnt = cnt + 2'd1;
            end
            default: cnt = cnt;
         endcase
         toks[cnt] = mk(K_END, line_ff, col_ff, pos_ff, 0);
         cnt = cnt + 2'd1;
         mode_in = M_IDLE;
         ovf_in  = 1'b0;
         pos_in  = '0;
         tsp_in  = '0;
         line_in = 1;
         col_in  = 1;
         tsl_in  = 1;
         tsc_in  = 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         ovf_ff  <= 1'b0;
         pos_ff  <= '0;
         tsp_ff  <= '0;
         line_ff <= 1;
         col_ff  <= 1;
         tsl_ff  <= 1;
         tsc_ff  <= 1;
      end else if (take) begin
         mode_ff <= mode_in;
         ovf_ff  <= ovf_in;
         pos_ff  <= pos_in;
         tsp_ff  <= tsp_in;
         line_ff <= line_in;
         col_ff  <= col_in;
         tsl_ff  <= tsl_in;
         tsc_ff  <= tsc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kbuf_ff <= kbuf_in;
      end
   end

   assign push         = take && (cnt != 2'd0);
   assign bundle.count = cnt;
   assign bundle.tok   = toks;
   assign status.mode  = mode_ff;
   assign status.pos   = pos_ff;

endmodule
`default_nettype wire

@@ design/sqlts_queue.sv @@
// Short bundle queue between the front and back parts of the scanner.
// Depends on sqlts_pkg for the bundle type and depth.
`default_nettype none
module sqlts_queue
   import sqlts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire bundle_type  push_data,
   input  wire logic        pop,
   output bundle_type       head,
   output logic             full,
   output logic             empty
);

   localparam int PTR_BITS = $clog2(Q_DEPTH);

   bundle_type              mem [Q_DEPTH];
   logic [PTR_BITS-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_BITS:0]       cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ff] <= push_data;
      end
   end

   assign head  = mem[rd_ff];
   assign full  = (cnt_ff == (PTR_BITS+1)'(Q_DEPTH));
   assign empty = (cnt_ff == '0);

endmodule
`default_nettype wire

@@ design/sqlts_back.sv @@
// Back part of the SQL token scanner: hands out the tokens of each bundle
// one per cycle, unless rsp_stall holds them, through an output register. Depends on sqlts_pkg.
`default_nettype none
module sqlts_back
   import sqlts_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire bundle_type  head,
   input  wire logic        empty,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output token_type        rsp_tok,
   output logic             rsp_last
);

   logic [1:0]  sub_ff, sub_in;
   logic        valid_ff, valid_in;
   token_type   tok_ff, tok_in;
   logic        last_ff, last_in;
   logic        load, is_last;

   always_comb begin
      load     = (!valid_ff || !rsp_stall) && !empty;
      is_last  = (sub_ff == head.count - 2'd1);
      pop      = load && is_last;
      sub_in   = sub_ff;
      valid_in = valid_ff;
      tok_in   = tok_ff;
      last_in  = last_ff;
      if (load) begin
         sub_in   = is_last ? 2'd0 : sub_ff + 2'd1;
         valid_in = 1'b1;
         tok_in   = head.tok[sub_ff];
         last_in  = is_last;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tok_ff  <= tok_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_tok   = tok_ff;
   assign rsp_last  = last_ff;

endmodule
`default_nettype wire

@@ design/sql_token_scanner.sv @@
// Top level of the SQL token scanner: front, bundle queue and back.
// Depends on sqlts_pkg, sqlts_front, sqlts_queue, sqlts_back and the defines header.
//
// Channel   Direction  Handshake               Payload
// req       in         req_valid / req_stall   req_action, req_text_byte
// rsp       out        rsp_valid / rsp_stall   rsp_token_kind .. rsp_last
//
// The front takes one item per cycle whenever the four-entry bundle queue has room.
// Each item yields zero to three tokens; the back hands out one token per cycle
// while rsp is not stalled, so the tokens of an item leave the output port in turn.
// Reset is synchronous and needs no clearing pass.
// A stall on rsp backs up into the queue, and a full queue raises req_stall.
`include "sql_token_scanner_defines.svh"
`default_nettype none
module sql_token_scanner
   import sqlts_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_action,
   input  wire logic [7:0]            req_text_byte,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [KIND_BITS-1:0]       rsp_token_kind,
   output logic [LC_BITS-1:0]         rsp_start_line,
   output logic [LC_BITS-1:0]         rsp_start_column,
   output logic [POS_BITS-1:0]        rsp_text_offset,
   output logic [POS_BITS-1:0]        rsp_text_length,
   output logic                       rsp_last
);

   logic              take, push, pop, q_full, q_empty;
   bundle_type        bundle, head;
   front_status_type  status;
   token_type         tok;

   assign take = req_valid && !req_stall;
   assign req_stall = q_full;

   sqlts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .action    (req_action),
      .text_byte (req_text_byte),
      .push      (push),
      .bundle    (bundle),
      .status    (status)
   );

   sqlts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (bundle),
      .pop       (pop),
      .head      (head),
      .full      (q_full),
      .empty     (q_empty)
   );

   sqlts_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (q_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_tok   (tok),
      .rsp_last  (rsp_last)
   );

   assign rsp_token_kind   = tok.kind;
   assign rsp_start_line   = tok.line;
   assign rsp_start_column = tok.column;
   assign rsp_text_offset  = tok.offset;
   assign rsp_text_length  = tok.length;

   `SQLTS_ASSERT(a_end_resets, clock, reset, take && req_action |=> status.mode == M_IDLE && status.pos == '0, "end item did not return the scanner to reset")
   `SQLTS_ASSERT(a_end_is_last, clock, reset, rsp_valid && rsp_token_kind == K_END |-> rsp_last, "end token not marked last")
   `SQLTS_ASSERT(a_bundle_cont, clock, reset, rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid, "gap inside a token bundle")
   `SQLTS_ASSERT(a_no_pop_empty, clock, reset, !(pop && q_empty), "queue popped while empty")

endmodule
`default_nettype wire
